// ===== src/umi_group_dedup_representative_top_macros.svh =====
// ----------------------------------------------------------------------------
// UMI group dedup assertion macros
// Shared concurrent assertion forms on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef UMI_GROUP_DEDUP_REPRESENTATIVE_TOP_MACROS_SVH
`define UMI_GROUP_DEDUP_REPRESENTATIVE_TOP_MACROS_SVH

// same-cycle implication
`define UGD_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UGD_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/umi_gdr_pkg.sv =====
// ----------------------------------------------------------------------------
// UMI group dedup package
// Shared constants, entry type, operation codes and back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package umi_gdr_pkg;

	localparam int GROUP_DEPTH_DEF = 1024;
	localparam int LEN_W           = 11;
	localparam int COUNT_W         = 16;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	localparam logic signed [LEN_W-1:0] LEN_NONE = -11'sd1;

	typedef struct packed {
		logic [31:0]              cluster;
		logic [15:0]              flags;
		logic [31:0]              id;
		logic signed [LEN_W-1:0]  len;
	} entry_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_WALK,
		BK_DRAIN,
		BK_DIV,
		BK_OUT
	} back_state_t;

endpackage

`default_nettype wire

// ===== src/umi_gdr_queue.sv =====
// ----------------------------------------------------------------------------
// UMI group dedup command queue
// Small register FIFO between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
`default_nettype none

module umi_gdr_queue #(
	parameter int W     = 8,
	parameter int DEPTH = umi_gdr_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      head,
	output logic              full,
	output logic              empty
);
	import umi_gdr_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== src/umi_gdr_front.sv =====
// ----------------------------------------------------------------------------
// UMI group dedup front
// Accepts records, tracks the open group and queues store writes and emits.
// ----------------------------------------------------------------------------
`default_nettype none

module umi_gdr_front #(
	parameter int GROUP_DEPTH = umi_gdr_pkg::GROUP_DEPTH_DEF,
	parameter int CMD_W       = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                operation,
	input  wire logic [63:0]                         umi_key,
	input  wire logic [10:0]                         priority_bits,
	input  wire logic [15:0]                         status_flags,
	input  wire logic [31:0]                         cluster_number,
	input  wire logic signed [umi_gdr_pkg::LEN_W-1:0] polya_length,
	input  wire logic [31:0]                         record_id,
	output logic                                     q_push,
	output logic [CMD_W-1:0]                         q_data,
	input  wire logic                                q_full
);
	import umi_gdr_pkg::*;

	localparam int AW = $clog2(GROUP_DEPTH);
	localparam int NW = $clog2(GROUP_DEPTH + 1);
	localparam int SW = LEN_W + AW;

	typedef struct packed {
		logic                  emit;
		logic [NW-1:0]         n;
		logic signed [SW-1:0]  sum;
		logic [COUNT_W-1:0]    count;
		logic                  ovf;
		logic                  wr;
		logic [AW-1:0]         addr;
		entry_t                ent;
	} cmd_t;

	logic                 grp_valid_q;
	logic [63:0]          key_q;
	logic [10:0]          best_q;
	logic [COUNT_W-1:0]   count_q;
	logic [NW-1:0]        stored_q;
	logic signed [SW-1:0] sum_q;
	logic                 ovf_q;

	logic   accept, is_flush, key_change, open_new, cont, higher, equal, equal_ok;
	cmd_t   cmd;
	entry_t ent;

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign is_flush   = (operation == OP_FLUSH);
	assign key_change = grp_valid_q && (umi_key != key_q);
	assign open_new   = !is_flush && (!grp_valid_q || key_change);
	assign cont       = !is_flush && grp_valid_q && !key_change;
	assign higher     = cont && ((priority_bits > best_q) || (stored_q == '0));
	assign equal      = cont && !higher && (priority_bits == best_q);
	assign equal_ok   = equal && (stored_q < NW'(GROUP_DEPTH));

	always_comb begin
		ent.cluster = cluster_number;
		ent.flags   = status_flags;
		ent.id      = record_id;
		ent.len     = polya_length;
		cmd.emit    = grp_valid_q && (is_flush || key_change);
		cmd.n       = stored_q;
		cmd.sum     = sum_q;
		cmd.count   = count_q;
		cmd.ovf     = ovf_q;
		cmd.wr      = open_new || higher || equal_ok;
		cmd.addr    = equal_ok ? stored_q[AW-1:0] : '0;
		cmd.ent     = ent;
	end

	assign q_push = accept && (cmd.emit || cmd.wr);
	assign q_data = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			key_q       <= '0;
			best_q      <= '0;
			count_q     <= '0;
			stored_q    <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
		end else if (accept) begin
			if (is_flush) begin
				grp_valid_q <= 1'b0;
				best_q      <= '0;
				count_q     <= '0;
				stored_q    <= '0;
				sum_q       <= '0;
				ovf_q       <= 1'b0;
			end else if (open_new) begin
				grp_valid_q <= 1'b1;
				key_q       <= umi_key;
				count_q     <= COUNT_W'(1);
				stored_q    <= NW'(1);
				sum_q       <= SW'(polya_length);
				best_q      <= priority_bits;
				ovf_q       <= 1'b0;
			end else begin
				if (count_q != '1) count_q <= count_q + 1'b1;
				if (higher) begin
					stored_q <= NW'(1);
					sum_q    <= SW'(polya_length);
					best_q   <= priority_bits;
					ovf_q    <= 1'b0;
				end else if (equal_ok) begin
					stored_q <= stored_q + 1'b1;
					sum_q    <= sum_q + SW'(polya_length);
				end else if (equal) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/umi_gdr_back.sv =====
// ----------------------------------------------------------------------------
// UMI group dedup back
// Owns the entry store, writes entries and walks a closed group to emit it.
// ----------------------------------------------------------------------------
`default_nettype none

module umi_gdr_back #(
	parameter int GROUP_DEPTH = umi_gdr_pkg::GROUP_DEPTH_DEF,
	parameter int CMD_W       = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                q_empty,
	input  wire logic [CMD_W-1:0]                    q_head,
	output logic                                     q_pop,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [31:0]                              rep_cluster_number,
	output logic [15:0]                              rep_flags,
	output logic [31:0]                              rep_record_id,
	output logic signed [umi_gdr_pkg::LEN_W-1:0]     group_polya_length,
	output logic [umi_gdr_pkg::COUNT_W-1:0]          duplicate_count,
	output logic                                     store_overflow
);
	import umi_gdr_pkg::*;

	localparam int AW  = $clog2(GROUP_DEPTH);
	localparam int NW  = $clog2(GROUP_DEPTH + 1);
	localparam int SW  = LEN_W + AW;
	localparam int PW  = LEN_W + NW + 1;
	localparam int DW  = SW + 2;
	localparam int DCW = $clog2(DW + 1);

	typedef struct packed {
		logic                  emit;
		logic [NW-1:0]         n;
		logic signed [SW-1:0]  sum;
		logic [COUNT_W-1:0]    count;
		logic                  ovf;
		logic                  wr;
		logic [AW-1:0]         addr;
		entry_t                ent;
	} cmd_t;

	cmd_t        head, cmd_q;
	back_state_t state_q, state_d;

	entry_t mem_q [GROUP_DEPTH];
	entry_t rd_data_q;

	logic [AW-1:0]        idx_q;
	logic                 v_s1_q, v_s2_q, first_q;
	logic signed [PW-1:0] prod_s2;
	entry_t               ent_s2;
	logic [PW-1:0]        bestd_q;
	entry_t               best_q;

	logic [DW-1:0]   dvd_q;
	logic [DW-1:0]   quo_q;
	logic [NW+1:0]   rem_q;
	logic [DCW-1:0]  dcnt_q;

	logic                 out_valid_q, out_free;
	logic                 walk_last, drained;
	logic                 rd_en, wr_en, load_out, div_start;
	logic [AW-1:0]        wr_addr;
	entry_t               wr_data;
	logic signed [PW-1:0] len_x, n_x, diff;
	logic [PW-1:0]        absd;
	logic [SW:0]          mag;
	logic [NW+1:0]        trial;
	logic [NW+1:0]        dvs;
	logic signed [LEN_W-1:0] mean, len_out;

	assign head      = q_head;
	assign out_free  = !out_valid_q || out_ready;
	assign walk_last = ({1'b0, idx_q} == (NW'(cmd_q.n) - 1'b1));
	assign drained   = !v_s1_q && !v_s2_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (!q_empty && head.emit) state_d = BK_WALK;
			BK_WALK:  if (walk_last) state_d = BK_DRAIN;
			BK_DRAIN: if (drained) state_d = BK_DIV;
			BK_DIV:   if (dcnt_q == DCW'(DW - 1)) state_d = BK_OUT;
			BK_OUT:   if (out_free) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = cmd_q.addr;
		wr_data   = cmd_q.ent;
		load_out  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				q_pop   = !q_empty;
				wr_en   = !q_empty && head.wr && !head.emit;
				wr_addr = head.addr;
				wr_data = head.ent;
			end
			BK_WALK:  rd_en = 1'b1;
			BK_DRAIN: div_start = drained;
			BK_DIV:   ;
			BK_OUT: begin
				load_out = out_free;
				wr_en    = out_free && cmd_q.wr;
			end
			default:  ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem_q[idx_q];
	end

	assign len_x = PW'(rd_data_q.len);
	assign n_x   = PW'({1'b0, cmd_q.n});
	assign diff  = prod_s2 - PW'(cmd_q.sum);
	assign absd  = diff[PW-1] ? PW'(-diff) : PW'(diff);
	assign mag   = cmd_q.sum[SW-1] ? (SW+1)'(-cmd_q.sum) : (SW+1)'(cmd_q.sum);
	assign dvs   = (NW+2)'({cmd_q.n, 1'b0});
	assign trial = {rem_q[NW:0], dvd_q[DW-1]};
	assign mean  = cmd_q.sum[SW-1] ? LEN_W'(-quo_q[LEN_W-1:0]) : LEN_W'(quo_q[LEN_W-1:0]);

	always_comb begin
		priority if (cmd_q.n == NW'(1)) len_out = best_q.len;
		else if (best_q.len < 0)        len_out = LEN_NONE;
		else                            len_out = mean;
	end

	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= head;
		if (rd_en) idx_q <= idx_q + 1'b1;
		else if (q_pop) idx_q <= '0;
		if (v_s1_q) begin
			prod_s2 <= len_x * n_x;
			ent_s2  <= rd_data_q;
		end
		if (v_s2_q && (first_q || absd < bestd_q)) begin
			bestd_q <= absd;
			best_q  <= ent_s2;
		end
		if (div_start) begin
			dvd_q  <= DW'({mag, 1'b0}) + DW'(cmd_q.n);
			rem_q  <= '0;
			quo_q  <= '0;
			dcnt_q <= '0;
		end else if (state_q == BK_DIV) begin
			dvd_q  <= {dvd_q[DW-2:0], 1'b0};
			dcnt_q <= dcnt_q + 1'b1;
			if (trial >= dvs) begin
				rem_q <= trial - dvs;
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
		if (load_out) begin
			rep_cluster_number <= best_q.cluster;
			rep_flags          <= best_q.flags;
			rep_record_id      <= best_q.id;
			group_polya_length <= len_out;
			duplicate_count    <= cmd_q.count;
			store_overflow     <= cmd_q.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1_q  <= rd_en;
			v_s2_q  <= v_s1_q;
			if (q_pop) first_q <= 1'b1;
			else if (v_s2_q) first_q <= 1'b0;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== src/umi_group_dedup_representative_top.sv =====
// ----------------------------------------------------------------------------
// UMI group dedup representative top
// Groups sorted records by UMI and emits one representative per group.
//
//   channel | direction | fields
//   --------+-----------+------------------------------------------------
//   in      | input     | operation umi_key priority_bits status_flags
//           |           | cluster_number polya_length record_id
//   out     | output    | rep_cluster_number rep_flags rep_record_id
//           |           | group_polya_length duplicate_count store_overflow
//
// The front accepts a record whenever the 4-word queue has room.
// Emitting a group of n stored entries holds the back through one pop, one
// store read per entry, a drain of the read pipeline, then a bit-serial
// divider for the rounded mean and a final load of the output.
// Reset clears all control; the entry store needs no clearing.
// A stalled output holds the back; a full queue drops in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module umi_group_dedup_representative_top #(
	parameter int GROUP_DEPTH = umi_gdr_pkg::GROUP_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                operation,
	input  wire logic [63:0]                         umi_key,
	input  wire logic [10:0]                         priority_bits,
	input  wire logic [15:0]                         status_flags,
	input  wire logic [31:0]                         cluster_number,
	input  wire logic signed [umi_gdr_pkg::LEN_W-1:0] polya_length,
	input  wire logic [31:0]                         record_id,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [31:0]                              rep_cluster_number,
	output logic [15:0]                              rep_flags,
	output logic [31:0]                              rep_record_id,
	output logic signed [umi_gdr_pkg::LEN_W-1:0]     group_polya_length,
	output logic [umi_gdr_pkg::COUNT_W-1:0]          duplicate_count,
	output logic                                     store_overflow
);
	import umi_gdr_pkg::*;

	localparam int AW    = $clog2(GROUP_DEPTH);
	localparam int NW    = $clog2(GROUP_DEPTH + 1);
	localparam int SW    = LEN_W + AW;
	localparam int CMD_W = 1 + NW + SW + COUNT_W + 1 + 1 + AW + $bits(entry_t);

	logic             q_push, q_pop, q_full, q_empty;
	logic [CMD_W-1:0] q_data, q_head;

	umi_gdr_front #(
		.GROUP_DEPTH (GROUP_DEPTH),
		.CMD_W       (CMD_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.umi_key        (umi_key),
		.priority_bits  (priority_bits),
		.status_flags   (status_flags),
		.cluster_number (cluster_number),
		.polya_length   (polya_length),
		.record_id      (record_id),
		.q_push         (q_push),
		.q_data         (q_data),
		.q_full         (q_full)
	);

	umi_gdr_queue #(
		.W     (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	umi_gdr_back #(
		.GROUP_DEPTH (GROUP_DEPTH),
		.CMD_W       (CMD_W)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_empty            (q_empty),
		.q_head             (q_head),
		.q_pop              (q_pop),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.rep_cluster_number (rep_cluster_number),
		.rep_flags          (rep_flags),
		.rep_record_id      (rep_record_id),
		.group_polya_length (group_polya_length),
		.duplicate_count    (duplicate_count),
		.store_overflow     (store_overflow)
	);

endmodule

`default_nettype wire

// ===== src/umi_gdr_checker.sv =====
// ----------------------------------------------------------------------------
// UMI group dedup checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "umi_group_dedup_representative_top_macros.svh"

module umi_gdr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] rep_record_id,
	input wire logic [15:0] duplicate_count,
	input wire logic        store_overflow
);

	`UGD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`UGD_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(rep_record_id) && $stable(duplicate_count), "result changed while stalled")
	`UGD_ASSERT_IMP(a_count_nonzero, out_valid, duplicate_count != 16'd0, "empty group emitted")
	`UGD_ASSERT_IMP(a_ovf_count, out_valid && store_overflow, duplicate_count > 16'd2, "overflow with too few records")

endmodule

bind umi_group_dedup_representative_top umi_gdr_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.rep_record_id   (rep_record_id),
	.duplicate_count (duplicate_count),
	.store_overflow  (store_overflow)
);

`default_nettype wire

// ===== tb/sv/umi_group_dedup_representative_top_tb.sv =====
// ----------------------------------------------------------------------------
// UMI group dedup representative testbench
// Drives sorted record words and flushes through the valid/ready input,
// predicts each group's representative word, and checks every output word
// field by field. Covers ties, priority takeover, negative lengths and store
// overflow, with random bursts and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module umi_group_dedup_representative_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import umi_gdr_pkg::*;

	localparam int DEPTH     = GROUP_DEPTH_DEF;
	localparam int MAX_CYCLE = 3000000;

	typedef struct {
		logic [31:0]       cluster;
		logic [15:0]       flags;
		logic [31:0]       id;
		logic signed [10:0] len;
		logic [15:0]       count;
		logic              ovf;
	} rep_word_t;

	class group_rep_board;
		bit          open_grp;
		logic [63:0] key_q;
		int          prio_q;
		int          count_q;
		int          n_stored;
		longint      sum_q;
		bit          ovf_q;
		entry_t      store[DEPTH];
		rep_word_t   pending[$];
		int          errors;

		function rep_word_t pick_rep();
			rep_word_t r;
			int        best;
			longint    d;
			longint    bd;
			longint    q;
			longint    mag;
			best = 0;
			if (n_stored <= 1) begin
				r.len = store[0].len;
			end else begin
				bd = longint'(store[0].len) * n_stored - sum_q;
				if (bd < 0) bd = -bd;
				for (int i = 1; i < n_stored; i++) begin
					d = longint'(store[i].len) * n_stored - sum_q;
					if (d < 0) d = -d;
					if (d < bd) begin
						bd = d;
						best = i;
					end
				end
				if (store[best].len >= 0) begin
					mag = (sum_q < 0) ? -sum_q : sum_q;
					q = (2 * mag + n_stored) / (2 * n_stored);
					if (sum_q < 0) q = -q;
					r.len = q[10:0];
				end else begin
					r.len = LEN_NONE;
				end
			end
			r.cluster = store[best].cluster;
			r.flags   = store[best].flags;
			r.id      = store[best].id;
			r.count   = count_q[15:0];
			r.ovf     = ovf_q;
			return r;
		endfunction

		function void take_first(entry_t e, int p);
			store[0] = e;
			n_stored = 1;
			sum_q    = e.len;
			prio_q   = p;
			ovf_q    = 0;
		endfunction

		function void note_word(logic op, logic [63:0] k, logic [10:0] p, entry_t e);
			if (op == OP_FLUSH) begin
				if (open_grp) pending.push_back(pick_rep());
				open_grp = 0;
				count_q  = 0;
				n_stored = 0;
				sum_q    = 0;
				ovf_q    = 0;
				prio_q   = 0;
				return;
			end
			if (open_grp && k != key_q) begin
				pending.push_back(pick_rep());
				open_grp = 0;
			end
			if (!open_grp) begin
				open_grp = 1;
				key_q    = k;
				count_q  = 1;
				take_first(e, p);
				return;
			end
			if (count_q < 65535) count_q++;
			if (int'(p) > prio_q || n_stored == 0) begin
				take_first(e, p);
			end else if (int'(p) == prio_q) begin
				if (n_stored < DEPTH) begin
					store[n_stored] = e;
					n_stored++;
					sum_q += e.len;
				end else begin
					ovf_q = 1;
				end
			end
		endfunction

		function void check_word(rep_word_t a);
			rep_word_t x;
			if (pending.size() == 0) begin
				$error("unexpected output word");
				errors++;
				return;
			end
			x = pending.pop_front();
			if (a.cluster !== x.cluster) begin
				$error("rep_cluster_number exp %h got %h", x.cluster, a.cluster); errors++;
			end
			if (a.flags !== x.flags) begin
				$error("rep_flags exp %h got %h", x.flags, a.flags); errors++;
			end
			if (a.id !== x.id) begin
				$error("rep_record_id exp %h got %h", x.id, a.id); errors++;
			end
			if (a.len !== x.len) begin
				$error("group_polya_length exp %0d got %0d", x.len, a.len); errors++;
			end
			if (a.count !== x.count) begin
				$error("duplicate_count exp %0d got %0d", x.count, a.count); errors++;
			end
			if (a.ovf !== x.ovf) begin
				$error("store_overflow exp %b got %b", x.ovf, a.ovf); errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [63:0] umi_key;
	logic [10:0] priority_bits;
	logic [15:0] status_flags;
	logic [31:0] cluster_number;
	logic signed [10:0] polya_length;
	logic [31:0] record_id;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] rep_cluster_number;
	logic [15:0] rep_flags;
	logic [31:0] rep_record_id;
	logic signed [10:0] group_polya_length;
	logic [15:0] duplicate_count;
	logic        store_overflow;

	group_rep_board board;
	int             cycles;
	int             burst_left;
	int             stall_mode;
	bit             no_gaps;

	umi_group_dedup_representative_top uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .umi_key(umi_key), .priority_bits(priority_bits),
		.status_flags(status_flags), .cluster_number(cluster_number),
		.polya_length(polya_length), .record_id(record_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.rep_cluster_number(rep_cluster_number), .rep_flags(rep_flags),
		.rep_record_id(rep_record_id), .group_polya_length(group_polya_length),
		.duplicate_count(duplicate_count), .store_overflow(store_overflow)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLE) begin
			$display("FAIL umi_group_dedup_representative_top");
			$finish;
		end
	end

	always @(posedge clk) begin
		entry_t    e;
		rep_word_t r;
		if (arst_n && in_valid && in_ready) begin
			e.cluster = cluster_number;
			e.flags   = status_flags;
			e.id      = record_id;
			e.len     = polya_length;
			board.note_word(operation, umi_key, priority_bits, e);
		end
		if (arst_n && out_valid && out_ready) begin
			r.cluster = rep_cluster_number;
			r.flags   = rep_flags;
			r.id      = rep_record_id;
			r.len     = group_polya_length;
			r.count   = duplicate_count;
			r.ovf     = store_overflow;
			board.check_word(r);
		end
	end

	always @(negedge clk) begin
		if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((cycles % 16) < 11);
		endcase
	end

	task automatic push(logic op, logic [63:0] k, logic [10:0] p, logic [15:0] f,
			logic [31:0] c, logic [10:0] ln, logic [31:0] id);
		int gap;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		operation      = op;
		umi_key        = k;
		priority_bits  = p;
		status_flags   = f;
		cluster_number = c;
		polya_length   = ln;
		record_id      = id;
		in_valid       = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic rec(logic [63:0] k, logic [10:0] p, logic [10:0] ln);
		push(OP_RECORD, k, p, 16'($urandom), $urandom, ln, $urandom);
	endtask

	task automatic flush();
		push(OP_FLUSH, {$urandom, $urandom}, 11'($urandom), 16'($urandom), $urandom,
			11'($urandom), $urandom);
	endtask

	task automatic settle();
		in_valid   = 1'b0;
		burst_left = 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (2 * DEPTH + 100) @(negedge clk);
	endtask

	function automatic logic [10:0] rand_len();
		case ($urandom_range(0, 5))
			0: return 11'h7FF;
			1: return 11'($urandom);
			2: return 11'h400 | 11'($urandom_range(0, 3));
			default: return 11'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic logic [10:0] rand_prio(logic [10:0] base);
		case ($urandom_range(0, 5))
			0: return base + 11'd1;
			1: return base - 11'd1;
			2: return 11'($urandom);
			default: return base;
		endcase
	endfunction

	initial begin
		logic [63:0] k;
		logic [10:0] bp;
		int          n;
		int          items;
		board      = new();
		cycles     = 0;
		burst_left = 0;
		stall_mode = 0;
		no_gaps    = 0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		out_ready  = 1'b0;
		operation  = OP_RECORD;
		umi_key    = '0;
		priority_bits  = '0;
		status_flags   = '0;
		cluster_number = '0;
		polya_length   = '0;
		record_id      = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		flush();
		push(OP_RECORD, '1, 11'h7FF, '1, '1, 11'h3FF, '1);
		push(OP_RECORD, '0, 11'h000, '0, '0, 11'h400, '0);
		rec(64'h1, 11'd5, 11'h7FF);
		flush();
		flush();
		rec(64'h2, 11'd3, 11'd1);
		rec(64'h2, 11'd3, 11'd2);
		rec(64'h2, 11'd3, 11'd2);
		rec(64'h2, 11'd3, 11'd1);
		rec(64'h3, 11'd1, 11'd10);
		rec(64'h3, 11'd9, 11'd20);
		rec(64'h3, 11'd9, 11'd24);
		rec(64'h3, 11'd2, 11'd0);
		rec(64'h4, 11'd7, 11'h7FF);
		rec(64'h4, 11'd7, 11'h7FE);
		rec(64'h4, 11'd7, 11'd5);
		rec(64'h5, 11'd0, 11'h400);
		rec(64'h5, 11'd0, 11'h3FF);
		rec(64'h5, 11'd0, 11'h7FF);
		flush();
		settle();

		no_gaps = 1;
		k  = {$urandom, $urandom};
		bp = 11'd100;
		rec(k, bp, 11'd3);
		for (int i = 0; i < DEPTH + 6; i++) rec(k, bp, rand_len());
		flush();
		no_gaps = 0;
		settle();

		items = 0;
		while (items < 550) begin
			if ($urandom_range(0, 9) == 0) begin
				push(OP_RECORD, {$urandom, $urandom}, 11'($urandom), 16'($urandom),
					$urandom, 11'($urandom), $urandom);
				items++;
			end else if ($urandom_range(0, 14) == 0) begin
				flush();
				items++;
			end else begin
				k  = {$urandom, $urandom};
				bp = 11'($urandom);
				n  = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 6);
				for (int i = 0; i < n; i++) rec(k, rand_prio(bp), rand_len());
				items += n;
			end
			if (items > 250 && items < 280) begin
				in_valid   = 1'b0;
				burst_left = 0;
				while (board.pending.size() != 0) @(negedge clk);
			end
		end
		flush();
		settle();

		if (board.errors == 0)
			$display("PASS umi_group_dedup_representative_top");
		else
			$display("FAIL umi_group_dedup_representative_top");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/umi_gdr_pkg.sv
src/umi_gdr_queue.sv
src/umi_gdr_front.sv
src/umi_gdr_back.sv
src/umi_group_dedup_representative_top.sv
src/umi_gdr_checker.sv
tb/sv/umi_group_dedup_representative_top_tb.sv
